// ===== hdl/iptp_pkg.sv =====
package iptp_pkg;

   // Default length of the link header ahead of the IPv4 header
   localparam int unsigned LINK_HEADER_BYTES_DEF = 14;

   // Verdict codes
   localparam logic [2:0] VERDICT_TCP_OK    = 3'd0;
   localparam logic [2:0] VERDICT_BAD_IP    = 3'd1;
   localparam logic [2:0] VERDICT_UDP       = 3'd2;
   localparam logic [2:0] VERDICT_ICMP      = 3'd3;
   localparam logic [2:0] VERDICT_IP        = 3'd4;
   localparam logic [2:0] VERDICT_OTHER     = 3'd5;
   localparam logic [2:0] VERDICT_BAD_TCP   = 3'd6;
   localparam logic [2:0] VERDICT_TRUNCATED = 3'd7;

   // IPv4 protocol numbers
   localparam logic [7:0] PROTO_IP   = 8'd0;
   localparam logic [7:0] PROTO_ICMP = 8'd1;
   localparam logic [7:0] PROTO_TCP  = 8'd6;
   localparam logic [7:0] PROTO_UDP  = 8'd17;

   localparam logic [5:0] MIN_HDR_BYTES      = 6'd20;
   localparam logic [7:0] OFFSET_NIBBLE_MASK = 8'hf0;

   // Verdict queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One verdict event with everything captured for the frame
   typedef struct packed {
      logic [2:0]  verdict;
      logic [5:0]  ip_len;
      logic [15:0] total_len;
      logic [7:0]  proto;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [5:0]  tcp_len;
   } event_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== hdl/iptp_if.sv =====
interface iptp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_end;

   modport source (output valid, output frame_byte, output frame_end, input ready);
   modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface iptp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  verdict;
   logic [31:0] packet_number;
   logic [5:0]  ip_header_bytes;
   logic [7:0]  protocol_number;
   logic [31:0] source_address;
   logic [31:0] destination_address;
   logic [15:0] source_port;
   logic [15:0] destination_port;
   logic [5:0]  tcp_header_bytes;
   logic [15:0] payload_bytes;

   modport source (
      output valid, output verdict, output packet_number, output ip_header_bytes,
      output protocol_number, output source_address, output destination_address,
      output source_port, output destination_port, output tcp_header_bytes,
      output payload_bytes, input ready
   );
   modport sink (
      input valid, input verdict, input packet_number, input ip_header_bytes,
      input protocol_number, input source_address, input destination_address,
      input source_port, input destination_port, input tcp_header_bytes,
      input payload_bytes, output ready
   );
endinterface

// ===== hdl/iptp_front.sv =====
module iptp_front #(
   parameter int unsigned LINK_HEADER_BYTES = iptp_pkg::LINK_HEADER_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   iptp_req_if.sink                   req_chan,
   input  iptp_pkg::queue_status_type q_status,
   output logic                       ev_push,
   output iptp_pkg::event_type        ev
);
   import iptp_pkg::*;

   localparam logic [6:0] LINK_POS = 7'(LINK_HEADER_BYTES);
   localparam logic [6:0] POS_MAX  = 7'd127;

   // IP header byte offsets
   localparam logic [6:0] OFS_IHL      = 7'd0;
   localparam logic [6:0] OFS_TLEN_HI  = 7'd2;
   localparam logic [6:0] OFS_TLEN_LO  = 7'd3;
   localparam logic [6:0] OFS_PROTO    = 7'd9;
   localparam logic [6:0] OFS_SRC_0    = 7'd12;
   localparam logic [6:0] OFS_SRC_3    = 7'd15;
   localparam logic [6:0] OFS_DST_0    = 7'd16;
   localparam logic [6:0] OFS_DST_3    = 7'd19;
   // TCP header byte offsets
   localparam logic [6:0] OFS_PORTS_3  = 7'd3;
   localparam logic [6:0] OFS_DOFF     = 7'd12;

   logic [6:0]  pos_ff, pos_in;
   logic        issued_ff, issued_in;
   logic [5:0]  ip_len_ff, ip_len_in;
   logic [15:0] total_ff, total_in;
   logic [7:0]  proto_ff, proto_in;
   logic [31:0] src_ff, src_in;
   logic [31:0] dst_ff, dst_in;
   logic [31:0] ports_ff, ports_in;

   logic        accept;
   logic [7:0]  b;
   logic [7:0]  doff_masked;
   logic [6:0]  idx;
   logic [6:0]  tcp_idx;
   logic [5:0]  ihl4;
   logic [5:0]  doff4;
   logic        hdr_valid;
   logic [2:0]  hdr_verdict;
   logic [5:0]  hdr_tcp_len;

   assign req_chan.ready = q_status.not_full;
   assign accept      = req_chan.valid & req_chan.ready;
   assign b           = req_chan.frame_byte;
   assign idx         = pos_ff - LINK_POS;
   assign tcp_idx     = idx - {1'b0, ip_len_ff};
   assign ihl4        = {b[3:0], 2'b00};
   assign doff_masked = b & OFFSET_NIBBLE_MASK;
   assign doff4       = {doff_masked[7:4], 2'b00};

   always_comb begin
      ip_len_in   = ip_len_ff;
      total_in    = total_ff;
      proto_in    = proto_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      ports_in    = ports_ff;
      hdr_valid   = 1'b0;
      hdr_verdict = VERDICT_TCP_OK;
      hdr_tcp_len = 6'd0;
      if (!issued_ff && pos_ff >= LINK_POS) begin
         priority if (idx == OFS_IHL) begin
            ip_len_in = ihl4;
            if (ihl4 < MIN_HDR_BYTES) begin
               hdr_valid   = 1'b1;
               hdr_verdict = VERDICT_BAD_IP;
            end
         end else if (idx == OFS_TLEN_HI || idx == OFS_TLEN_LO) begin
            total_in = {total_ff[7:0], b};
         end else if (idx == OFS_PROTO) begin
            proto_in = b;
         end else if (idx >= OFS_SRC_0 && idx <= OFS_SRC_3) begin
            src_in = {src_ff[23:0], b};
         end else if (idx >= OFS_DST_0 && idx <= OFS_DST_3) begin
            dst_in = {dst_ff[23:0], b};
            if (idx == OFS_DST_3 && proto_ff != PROTO_TCP) begin
               hdr_valid = 1'b1;
               priority if (proto_ff == PROTO_UDP)  hdr_verdict = VERDICT_UDP;
               else if (proto_ff == PROTO_ICMP)     hdr_verdict = VERDICT_ICMP;
               else if (proto_ff == PROTO_IP)       hdr_verdict = VERDICT_IP;
               else                                 hdr_verdict = VERDICT_OTHER;
            end
         end else if (idx >= {1'b0, ip_len_ff}) begin
            if (tcp_idx <= OFS_PORTS_3) begin
               ports_in = {ports_ff[23:0], b};
            end else if (tcp_idx == OFS_DOFF) begin
               hdr_valid   = 1'b1;
               hdr_tcp_len = doff4;
               hdr_verdict = (doff4 < MIN_HDR_BYTES) ? VERDICT_BAD_TCP : VERDICT_TCP_OK;
            end
         end else begin
            // remaining header bytes carry nothing we keep
         end
      end
   end

   // Event carries the captures including this byte
   always_comb begin
      ev.verdict   = hdr_valid ? hdr_verdict : VERDICT_TRUNCATED;
      ev.ip_len    = ip_len_in;
      ev.total_len = total_in;
      ev.proto     = proto_in;
      ev.src_addr  = src_in;
      ev.dst_addr  = dst_in;
      ev.ports     = ports_in;
      ev.tcp_len   = hdr_tcp_len;
      ev_push      = accept & (hdr_valid | (req_chan.frame_end & ~issued_ff));
   end

   assign issued_in = issued_ff | hdr_valid;
   assign pos_in    = (pos_ff < POS_MAX) ? pos_ff + 7'd1 : pos_ff;

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.frame_end)) begin
         pos_ff    <= '0;
         issued_ff <= 1'b0;
         ip_len_ff <= '0;
         total_ff  <= '0;
         proto_ff  <= '0;
         src_ff    <= '0;
         dst_ff    <= '0;
         ports_ff  <= '0;
      end else if (accept) begin
         pos_ff    <= pos_in;
         issued_ff <= issued_in;
         ip_len_ff <= ip_len_in;
         total_ff  <= total_in;
         proto_ff  <= proto_in;
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         ports_ff  <= ports_in;
      end
   end

endmodule

// ===== hdl/iptp_queue.sv =====
module iptp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  iptp_pkg::event_type        push_data,
   input  logic                       pop,
   output iptp_pkg::event_type        head_data,
   output iptp_pkg::queue_status_type status
);
   import iptp_pkg::*;

   event_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.not_full  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign do_push   = push & status.not_full;
   assign do_pop    = pop & status.not_empty;
   assign head_data = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/iptp_back.sv =====
module iptp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  iptp_pkg::event_type        head_data,
   input  iptp_pkg::queue_status_type q_status,
   output logic                       pop,
   iptp_rsp_if.source                 rsp_chan
);
   import iptp_pkg::*;

   logic        valid_ff;
   logic [31:0] counter_ff;
   logic [2:0]  verdict_ff;
   logic [31:0] number_ff;
   logic [5:0]  ip_len_ff;
   logic [7:0]  proto_ff;
   logic [31:0] src_ff, dst_ff;
   logic [15:0] sport_ff, dport_ff;
   logic [5:0]  tcp_len_ff;
   logic [15:0] payload_ff;

   logic        load;
   logic        is_tcp, is_fault;
   logic [6:0]  hdrs;
   logic [15:0] payload_in;

   assign load     = q_status.not_empty & (~valid_ff | rsp_chan.ready);
   assign pop      = load;
   assign is_tcp   = (head_data.verdict == VERDICT_TCP_OK) ||
                     (head_data.verdict == VERDICT_BAD_TCP);
   assign is_fault = (head_data.verdict == VERDICT_BAD_IP);
   assign hdrs     = {1'b0, head_data.ip_len} + {1'b0, head_data.tcp_len};

   always_comb begin
      payload_in = '0;
      if (head_data.verdict == VERDICT_TCP_OK && head_data.total_len > {9'd0, hdrs})
         payload_in = head_data.total_len - {9'd0, hdrs};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         counter_ff <= '0;
      end else begin
         if (load) begin
            valid_ff   <= 1'b1;
            counter_ff <= counter_ff + 32'd1;
         end else if (rsp_chan.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= head_data.verdict;
         number_ff  <= counter_ff + 32'd1;
         ip_len_ff  <= head_data.ip_len;
         proto_ff   <= is_fault ? 8'd0 : head_data.proto;
         src_ff     <= is_fault ? 32'd0 : head_data.src_addr;
         dst_ff     <= is_fault ? 32'd0 : head_data.dst_addr;
         sport_ff   <= is_tcp ? head_data.ports[31:16] : 16'd0;
         dport_ff   <= is_tcp ? head_data.ports[15:0] : 16'd0;
         tcp_len_ff <= is_tcp ? head_data.tcp_len : 6'd0;
         payload_ff <= payload_in;
      end
   end

   assign rsp_chan.valid               = valid_ff;
   assign rsp_chan.verdict             = verdict_ff;
   assign rsp_chan.packet_number       = number_ff;
   assign rsp_chan.ip_header_bytes     = ip_len_ff;
   assign rsp_chan.protocol_number     = proto_ff;
   assign rsp_chan.source_address      = src_ff;
   assign rsp_chan.destination_address = dst_ff;
   assign rsp_chan.source_port         = sport_ff;
   assign rsp_chan.destination_port    = dport_ff;
   assign rsp_chan.tcp_header_bytes    = tcp_len_ff;
   assign rsp_chan.payload_bytes       = payload_ff;

endmodule

// ===== hdl/ipv4_tcp_header_parser_top.sv =====
// Channel    Dir  Transaction
// ---------  ---  ---------------------------------------------------------
// req_chan   in   one frame byte (frame_byte) plus last-byte flag (frame_end)
// rsp_chan   out  one verdict per frame with captured IPv4/TCP header fields
//
// One byte transaction per clock while req_chan.ready is high; the front
// captures and classifies each byte combinationally. A verdict is written into
// a 2-entry queue when the deciding byte's transaction completes, and from the
// queue into the output register behind rsp_chan once that register is empty
// or being taken. req_chan.ready drops only while the queue holds two verdicts,
// i.e. when the result side stalls. Reset is synchronous, active high, no sweep.
module ipv4_tcp_header_parser_top #(
   parameter int unsigned LINK_HEADER_BYTES = iptp_pkg::LINK_HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   iptp_req_if.sink    req_chan,
   iptp_rsp_if.source  rsp_chan
);
   import iptp_pkg::*;

   // Front to queue: verdict events, at most one per frame
   event_type        ev;
   logic             ev_push;
   // Queue to back: oldest pending verdict
   event_type        head_data;
   queue_status_type q_status;
   logic             pop;

   // Front: tracks byte position in the frame, captures IP/TCP fields and
   // decides the verdict on the byte that settles it (or frame end).
   iptp_front #(
      .LINK_HEADER_BYTES (LINK_HEADER_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .ev_push  (ev_push),
      .ev       (ev)
   );

   // Short queue so byte intake keeps going while a result waits
   iptp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (ev_push),
      .push_data (ev),
      .pop       (pop),
      .head_data (head_data),
      .status    (q_status)
   );

   // Back: packet numbering, payload length, field masking, output register
   iptp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_data (head_data),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

// ===== tb/iptp_frame_checker.sv =====
`timescale 1ns / 100ps

module iptp_frame_checker #(
   parameter int unsigned LINK_BYTES = iptp_pkg::LINK_HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   iptp_req_if         req_mon,
   iptp_rsp_if         rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending
);
   import iptp_pkg::*;

   typedef struct packed {
      logic [2:0]  verdict;
      logic [31:0] packet_number;
      logic [5:0]  ip_header_bytes;
      logic [7:0]  protocol_number;
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [5:0]  tcp_header_bytes;
      logic [15:0] payload_bytes;
   } verdict_rec_type;

   // per-frame capture state, plus the running verdict count
   logic [6:0]   byte_pos;
   logic         decided;
   logic [5:0]   ip_hdr_len;
   logic [15:0]  ip_total_len;
   logic [7:0]   ip_proto;
   logic [31:0]  ip_src;
   logic [31:0]  ip_dst;
   logic [31:0]  tcp_ports;
   logic [31:0]  verdict_count;

   verdict_rec_type verdicts_due[$];
   verdict_rec_type want;
   int unsigned     mismatches = 0;

   assign fail_count = mismatches;

   task clear_frame_state;
      byte_pos     = '0;
      decided      = 1'b0;
      ip_hdr_len   = '0;
      ip_total_len = '0;
      ip_proto     = '0;
      ip_src       = '0;
      ip_dst       = '0;
      tcp_ports    = '0;
   endtask

   task issue_verdict(input logic [2:0] code, input logic [5:0] tcp_len);
      verdict_rec_type rec;
      int unsigned     hdrs;
      rec = '0;
      verdict_count = verdict_count + 1;
      rec.verdict         = code;
      rec.packet_number   = verdict_count;
      rec.ip_header_bytes = ip_hdr_len;
      if (code != VERDICT_BAD_IP) begin
         rec.protocol_number     = ip_proto;
         rec.source_address      = ip_src;
         rec.destination_address = ip_dst;
      end
      if (code == VERDICT_TCP_OK || code == VERDICT_BAD_TCP) begin
         rec.source_port      = tcp_ports[31:16];
         rec.destination_port = tcp_ports[15:0];
         rec.tcp_header_bytes = tcp_len;
      end
      if (code == VERDICT_TCP_OK) begin
         hdrs = ip_hdr_len + tcp_len;
         if (ip_total_len > hdrs)
            rec.payload_bytes = 16'(ip_total_len - hdrs);
      end
      verdicts_due.push_back(rec);
      decided = 1'b1;
   endtask

   task parse_frame_byte(input logic [7:0] b, input logic last);
      int         idx;
      int         tofs;
      logic [5:0] tcp_len;
      if (!decided && byte_pos >= LINK_BYTES) begin
         idx = int'(byte_pos) - int'(LINK_BYTES);
         if (idx == 0) begin
            ip_hdr_len = {b[3:0], 2'b00};
            if (ip_hdr_len < MIN_HDR_BYTES)
               issue_verdict(VERDICT_BAD_IP, '0);
         end else if (idx == 2 || idx == 3) begin
            ip_total_len = {ip_total_len[7:0], b};
         end else if (idx == 9) begin
            ip_proto = b;
         end else if (idx >= 12 && idx <= 15) begin
            ip_src = {ip_src[23:0], b};
         end else if (idx >= 16 && idx <= 19) begin
            ip_dst = {ip_dst[23:0], b};
            if (idx == 19 && ip_proto != PROTO_TCP) begin
               case (ip_proto)
                  PROTO_UDP:  issue_verdict(VERDICT_UDP, '0);
                  PROTO_ICMP: issue_verdict(VERDICT_ICMP, '0);
                  PROTO_IP:   issue_verdict(VERDICT_IP, '0);
                  default:    issue_verdict(VERDICT_OTHER, '0);
               endcase
            end
         end else if (idx >= int'(ip_hdr_len)) begin
            tofs = idx - int'(ip_hdr_len);
            if (tofs <= 3) begin
               tcp_ports = {tcp_ports[23:0], b};
            end else if (tofs == 12) begin
               tcp_len = 6'(((b & OFFSET_NIBBLE_MASK) >> 4) * 4);
               issue_verdict(tcp_len < MIN_HDR_BYTES ? VERDICT_BAD_TCP : VERDICT_TCP_OK,
                             tcp_len);
            end
         end
      end
      if (last) begin
         if (!decided)
            issue_verdict(VERDICT_TRUNCATED, '0);
         clear_frame_state();
      end else if (byte_pos != 7'd127) begin
         byte_pos = byte_pos + 7'd1;
      end
   endtask

   task check_field(input string name, input logic [31:0] expected, input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0h, got %0h", name, expected, actual);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_frame_state();
         verdict_count = '0;
         verdicts_due.delete();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (verdicts_due.size() == 0) begin
               $error("verdict transaction with none expected, verdict %0d", rsp_mon.verdict);
               mismatches++;
            end else begin
               want = verdicts_due.pop_front();
               check_field("verdict", want.verdict, rsp_mon.verdict);
               check_field("packet_number", want.packet_number, rsp_mon.packet_number);
               check_field("ip_header_bytes", want.ip_header_bytes, rsp_mon.ip_header_bytes);
               check_field("protocol_number", want.protocol_number, rsp_mon.protocol_number);
               check_field("source_address", want.source_address, rsp_mon.source_address);
               check_field("destination_address", want.destination_address,
                           rsp_mon.destination_address);
               check_field("source_port", want.source_port, rsp_mon.source_port);
               check_field("destination_port", want.destination_port,
                           rsp_mon.destination_port);
               check_field("tcp_header_bytes", want.tcp_header_bytes,
                           rsp_mon.tcp_header_bytes);
               check_field("payload_bytes", want.payload_bytes, rsp_mon.payload_bytes);
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            parse_frame_byte(req_mon.frame_byte, req_mon.frame_end);
      end
      pending <= verdicts_due.size();
   end

endmodule

// ===== tb/tb_ipv4_tcp_header_parser_top.sv =====
`timescale 1ns / 100ps

// Drives Ethernet frames byte by byte into the header parser and gives the
// verdict. Prediction and comparison live in iptp_frame_checker.
module tb_ipv4_tcp_header_parser_top;
   import iptp_pkg::*;

   localparam int unsigned LINK = LINK_HEADER_BYTES_DEF;
   // receiver hold-off long enough to back the verdict queue up into req_chan
   localparam int unsigned HOLD_CYCLES = 300;

   logic        clock;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending;

   // steady: neither side idles; hold_off_req: receiver stalls for HOLD_CYCLES
   bit          steady = 1'b0;
   bit          hold_off_req = 1'b0;

   logic [7:0]  frame_q[$];
   int          bytes_sent = 0;

   iptp_req_if req_chan ();
   iptp_rsp_if rsp_chan ();

   ipv4_tcp_header_parser_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   iptp_frame_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Assemble one frame: link header, IPv4 header (options padded to IHL),
   // TCP header. cut > 0 forces the frame length, cut < 0 ends the frame at a
   // random byte before the deciding one, cut == 0 runs past it by tail bytes.
   task build_frame(input logic [3:0] ihl, input logic [7:0] proto,
                    input logic [15:0] total, input logic [31:0] src,
                    input logic [31:0] dst, input logic [15:0] sport,
                    input logic [15:0] dport, input logic [3:0] doff,
                    input int cut, input int tail);
      int hdr_len;
      int decide_at;
      int frame_len;
      frame_q.delete();
      hdr_len = (int'(ihl) * 4 < 20) ? 20 : int'(ihl) * 4;
      repeat (LINK) frame_q.push_back(8'($urandom));
      // version nibble is ignored by the block, so let it wander
      frame_q.push_back({($urandom_range(1) ? 4'h4 : 4'($urandom)), ihl});
      frame_q.push_back(8'($urandom));
      frame_q.push_back(total[15:8]);
      frame_q.push_back(total[7:0]);
      repeat (5) frame_q.push_back(8'($urandom));
      frame_q.push_back(proto);
      repeat (2) frame_q.push_back(8'($urandom));
      for (int k = 3; k >= 0; k--) frame_q.push_back(src[8*k +: 8]);
      for (int k = 3; k >= 0; k--) frame_q.push_back(dst[8*k +: 8]);
      repeat (hdr_len - 20) frame_q.push_back(8'($urandom));
      frame_q.push_back(sport[15:8]);
      frame_q.push_back(sport[7:0]);
      frame_q.push_back(dport[15:8]);
      frame_q.push_back(dport[7:0]);
      repeat (8) frame_q.push_back(8'($urandom));
      frame_q.push_back({doff, 4'($urandom)});
      repeat (7) frame_q.push_back(8'($urandom));

      // byte index where the block commits to a verdict
      if (int'(ihl) * 4 < 20)
         decide_at = LINK;
      else if (proto != PROTO_TCP)
         decide_at = LINK + 19;
      else
         decide_at = LINK + hdr_len + 12;

      if (cut < 0)
         frame_len = $urandom_range(decide_at, 1);
      else if (cut > 0)
         frame_len = cut;
      else
         frame_len = decide_at + 1 + tail;
      while (frame_q.size() > frame_len) void'(frame_q.pop_back());
      while (frame_q.size() < frame_len) frame_q.push_back(8'($urandom));
   endtask

   // Mostly well-formed headers with random content, some noise frames.
   task make_random_frame;
      logic [3:0]  ihl;
      logic [3:0]  doff;
      logic [7:0]  proto;
      logic [15:0] total;
      int          pick;
      int          cut;
      int          tail;
      if ($urandom_range(99) < 8) begin
         frame_q.delete();
         repeat ($urandom_range(60, 1)) frame_q.push_back(8'($urandom));
      end else begin
         ihl = ($urandom_range(99) < 10) ? 4'($urandom_range(4, 0))
                                         : 4'($urandom_range(15, 5));
         pick = $urandom_range(99);
         if (pick < 45)      proto = PROTO_TCP;
         else if (pick < 57) proto = PROTO_UDP;
         else if (pick < 67) proto = PROTO_ICMP;
         else if (pick < 75) proto = PROTO_IP;
         else                proto = 8'($urandom);
         doff = ($urandom_range(99) < 10) ? 4'($urandom_range(4, 0))
                                          : 4'($urandom_range(15, 5));
         pick = $urandom_range(99);
         if (pick < 40)
            total = 16'(int'(ihl) * 4 + int'(doff) * 4 + $urandom_range(200, 0));
         else if (pick < 70)
            total = 16'($urandom);
         else
            total = 16'($urandom_range(80, 0));
         pick = $urandom_range(99);
         cut  = (pick < 15) ? -1 : 0;
         tail = (pick >= 97) ? $urandom_range(180, 100) : $urandom_range(8, 0);
         build_frame(ihl, proto, total, $urandom, $urandom, 16'($urandom), 16'($urandom),
                     doff, cut, tail);
      end
   endtask

   // Offer each byte until its transaction completes. Random idle cycles go
   // in front of a byte unless the steady stretch is on.
   task send_frame;
      for (int k = 0; k < frame_q.size(); k++) begin
         while (!steady && $urandom_range(99) < 35) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
         req_chan.valid      <= 1'b1;
         req_chan.frame_byte <= frame_q[k];
         req_chan.frame_end  <= (k == frame_q.size() - 1);
         @(posedge clock);
         while (req_chan.ready !== 1'b1) @(posedge clock);
         bytes_sent++;
      end
   endtask

   // Result side: random back-pressure, none during the steady stretch, and
   // one long hold-off on request.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(99) >= 35);
         end
      end
   end

   // Stimulus
   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.frame_byte <= 8'h00;
      req_chan.frame_end  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed frames
      // header length below minimum, zero and one short of it
      build_frame(4'd0, PROTO_TCP, 16'h0000, '0, '0, '0, '0, 4'd5, 0, 2);
      send_frame();
      build_frame(4'd4, 8'hff, 16'hffff, '1, '1, '1, '1, 4'hf, 0, 0);
      send_frame();
      // each non-TCP protocol class, address extremes
      build_frame(4'd5, PROTO_UDP, 16'h1234, 32'hffff_ffff, 32'h0, '0, '0, 4'd5, 0, 0);
      send_frame();
      build_frame(4'd5, PROTO_ICMP, 16'h0054, 32'h0, 32'hffff_ffff, '0, '0, 4'd5, 0, 1);
      send_frame();
      build_frame(4'd6, PROTO_IP, 16'h0018, 32'h0a00_0001, 32'hc0a8_0101, '1, '1, 4'd5,
                  0, 0);
      send_frame();
      build_frame(4'd5, 8'hff, 16'hffff, 32'h8000_0001, 32'h7fff_fffe, '0, '0, 4'd5, 0, 0);
      send_frame();
      // TCP: largest headers with full total length, then minimum headers with a 100-byte payload
      build_frame(4'd15, PROTO_TCP, 16'hffff, '1, '1, 16'hffff, 16'h0000, 4'hf, 0, 3);
      send_frame();
      build_frame(4'd5, PROTO_TCP, 16'd140, 32'ha5a5_a5a5, 32'h5a5a_5a5a, 16'd80,
                  16'd1024, 4'd5, 0, 0);
      send_frame();
      // TCP data offset too small
      build_frame(4'd5, PROTO_TCP, 16'd100, $urandom, $urandom, 16'h1111, 16'h2222, 4'd4,
                  0, 0);
      send_frame();
      build_frame(4'd7, PROTO_TCP, 16'd0, $urandom, $urandom, 16'h0001, 16'h8000, 4'd0,
                  0, 4);
      send_frame();
      // total length shorter than the headers gives zero payload
      build_frame(4'd5, PROTO_TCP, 16'd10, $urandom, $urandom, 16'h0000, 16'hffff, 4'd5,
                  0, 0);
      send_frame();

      // Back-to-back stretch on both sides from here through the long frame
      steady = 1'b1;
      // truncations: one byte, inside link header, on IP byte 0, mid source,
      // inside ports, one byte short of the offset byte
      build_frame(4'd5, PROTO_UDP, 16'd28, $urandom, $urandom, '0, '0, 4'd5, 1, 0);
      send_frame();
      build_frame(4'd5, PROTO_UDP, 16'd28, $urandom, $urandom, '0, '0, 4'd5, LINK, 0);
      send_frame();
      build_frame(4'd5, PROTO_TCP, 16'd40, $urandom, $urandom, '0, '0, 4'd5, LINK + 1, 0);
      send_frame();
      // bad header length decided on the last byte: no truncation verdict
      build_frame(4'd2, PROTO_TCP, 16'd40, $urandom, $urandom, '0, '0, 4'd5, LINK + 1, 0);
      send_frame();
      build_frame(4'd5, PROTO_TCP, 16'd40, 32'hdead_beef, $urandom, '0, '0, 4'd5,
                  LINK + 14, 0);
      send_frame();
      build_frame(4'd5, PROTO_TCP, 16'd40, $urandom, $urandom, 16'habcd, 16'h1234, 4'd5,
                  LINK + 22, 0);
      send_frame();
      build_frame(4'd5, PROTO_TCP, 16'd40, $urandom, $urandom, 16'habcd, 16'h1234, 4'd5,
                  LINK + 32, 0);
      send_frame();
      // frame past 127 bytes, position counter saturates
      build_frame(4'd5, PROTO_UDP, 16'd200, $urandom, $urandom, '0, '0, 4'd5, 0, 100);
      send_frame();
      steady = 1'b0;

      // Drain completely before the back-pressure phase
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);

      // Receiver holds off while frames keep coming: the verdict queue fills
      // and req_chan.ready must drop
      hold_off_req = 1'b1;
      repeat (5) begin
         make_random_frame();
         send_frame();
      end

      // Random frames up to the byte budget
      while (bytes_sent < 950) begin
         make_random_frame();
         send_frame();
      end

      // Wait for the last verdicts, then wait out anything stray
      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/iptp_pkg.sv
hdl/iptp_if.sv
hdl/iptp_front.sv
hdl/iptp_queue.sv
hdl/iptp_back.sv
hdl/ipv4_tcp_header_parser_top.sv
tb/iptp_frame_checker.sv
tb/tb_ipv4_tcp_header_parser_top.sv
